@@ sv/mtc_pkg.sv @@
// Morse text codec package: state and job types, code table, lookup functions.
// No dependencies; imported by mtc_emitter, morse_text_codec and the testbench.
`default_nettype none

package mtc_pkg;

    localparam int NUM_CODES   = 42;
    localparam int STATE_DEPTH = 1;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic       decode_mode;
        logic [6:0] token_symbols;
        logic [3:0] token_length;
        logic       token_bad;
    } mtc_state_t;

    localparam int STATE_W = $bits(mtc_state_t);

    // nsym symbol words (bit i set = dash), then final_byte with last_of_run
    typedef struct packed {
        logic [2:0] nsym;
        logic [6:0] syms;
        logic [7:0] final_byte;
    } mtc_job_t;

    // {character, length, symbols in reading order right-aligned, dash = 1}
    localparam logic [17:0] CODE_TABLE [NUM_CODES] = '{
        {8'h41, 3'd2, 7'b0000001}, {8'h42, 3'd4, 7'b0001000},
        {8'h43, 3'd4, 7'b0001010}, {8'h44, 3'd3, 7'b0000100},
        {8'h45, 3'd1, 7'b0000000}, {8'h46, 3'd4, 7'b0000010},
        {8'h47, 3'd3, 7'b0000110}, {8'h48, 3'd4, 7'b0000000},
        {8'h49, 3'd2, 7'b0000000}, {8'h4A, 3'd4, 7'b0000111},
        {8'h4B, 3'd3, 7'b0000101}, {8'h4C, 3'd4, 7'b0000100},
        {8'h4D, 3'd2, 7'b0000011}, {8'h4E, 3'd2, 7'b0000010},
        {8'h4F, 3'd3, 7'b0000111}, {8'h50, 3'd4, 7'b0000110},
        {8'h51, 3'd4, 7'b0001101}, {8'h52, 3'd3, 7'b0000010},
        {8'h53, 3'd3, 7'b0000000}, {8'h54, 3'd1, 7'b0000001},
        {8'h55, 3'd3, 7'b0000001}, {8'h56, 3'd4, 7'b0000001},
        {8'h57, 3'd3, 7'b0000011}, {8'h58, 3'd4, 7'b0001001},
        {8'h59, 3'd4, 7'b0001011}, {8'h5A, 3'd4, 7'b0001100},
        {8'h31, 3'd5, 7'b0001111}, {8'h32, 3'd5, 7'b0000111},
        {8'h33, 3'd5, 7'b0000011}, {8'h34, 3'd5, 7'b0000001},
        {8'h35, 3'd5, 7'b0000000}, {8'h36, 3'd5, 7'b0010000},
        {8'h37, 3'd5, 7'b0011000}, {8'h38, 3'd5, 7'b0011100},
        {8'h39, 3'd5, 7'b0011110}, {8'h30, 3'd5, 7'b0011111},
        {8'h2C, 3'd6, 7'b0110011}, {8'h21, 3'd6, 7'b0101011},
        {8'h3F, 3'd6, 7'b0001100}, {8'h2E, 3'd6, 7'b0010101},
        {8'h27, 3'd6, 7'b0011110}, {8'h20, 3'd7, 7'b0000000}
    };

    // reading order to first-symbol-in-bit-0
    function automatic logic [6:0] lsb_first(input logic [2:0] len, input logic [6:0] pat);
        logic [6:0] r;
        logic [2:0] k;
        r = '0;
        for (int i = 0; i < 7; i++) begin
            k = len - 3'(i) - 3'd1;
            if (3'(i) < len) begin
                r[i] = pat[k];
            end
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_symbol(input logic [7:0] b);
        return (b == CH_DOT) || (b == CH_DASH);
    endfunction

    function automatic mtc_job_t enc_lookup(input logic [7:0] b);
        mtc_job_t   job;
        logic [7:0] u;
        logic       found;
        u     = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
        found = 1'b0;
        job   = '{nsym: 3'd0, syms: 7'd0, final_byte: CH_SPACE};
        for (int i = 0; i < NUM_CODES; i++) begin
            if (!found && CODE_TABLE[i][17:10] == u) begin
                found    = 1'b1;
                job.nsym = CODE_TABLE[i][9:7];
                job.syms = lsb_first(CODE_TABLE[i][9:7], CODE_TABLE[i][6:0]);
            end
        end
        return job;
    endfunction

    function automatic logic [7:0] dec_lookup(input mtc_state_t st);
        logic [7:0] ch;
        logic       found;
        ch    = CH_SPACE;
        found = 1'b0;
        if (!st.token_bad && st.token_length != 4'd0 && st.token_length <= 4'd7) begin
            for (int i = 0; i < NUM_CODES; i++) begin
                if (!found && {1'b0, CODE_TABLE[i][9:7]} == st.token_length
                        && lsb_first(CODE_TABLE[i][9:7], CODE_TABLE[i][6:0])
                           == st.token_symbols) begin
                    found = 1'b1;
                    ch    = CODE_TABLE[i][17:10];
                end
            end
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ sv/mtc_ram.sv @@
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module mtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                     aclk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/mtc_emitter.sv @@
// Result serialiser: turns one job into its symbol words and final word.
// Depends on mtc_pkg.
`default_nettype none

module mtc_emitter
    import mtc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     job_valid,
    input  wire mtc_job_t job,
    output logic          job_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_last_of_run
);

    logic       busy_reg, busy_next;
    mtc_job_t   job_reg, job_next;
    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       out_load;
    logic       at_final;

    assign out_load  = !m_valid_reg || m_ready;
    assign at_final  = (idx_reg == job_reg.nsym);
    assign job_ready = !busy_reg || (out_load && at_final);

    always_comb begin
        busy_next    = busy_reg;
        job_next     = job_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        if (out_load) begin
            m_valid_next = 1'b0;
            if (busy_reg) begin
                m_valid_next = 1'b1;
                if (at_final) begin
                    byte_next = job_reg.final_byte;
                    last_next = 1'b1;
                    busy_next = 1'b0;
                end else begin
                    byte_next = job_reg.syms[idx_reg] ? CH_DASH : CH_DOT;
                    last_next = 1'b0;
                    idx_next  = idx_reg + 3'd1;
                end
            end
        end
        if (job_valid && job_ready) begin
            busy_next = 1'b1;
            job_next  = job;
            idx_next  = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= 3'd0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
        job_reg  <= job_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

`default_nettype wire

@@ sv/morse_text_codec.sv @@
// An input word passes the stage 1 register, then the emitter's job and output registers.
// An encoded byte with n symbols gives n+1 result words (at most 8) and waits in stage 1
// until the emitter takes its job; decode bytes go one per cycle while m_ready is high,
// set by the emitter's one-word-per-cycle output. Codec state lives in a one-entry RAM,
// read on accept and written back as stage 1 goes, with the write forwarded to the next
// word. It reads zero after reset (encode mode, empty token) until written; no clearing pass.
`default_nettype none

module morse_text_codec
    import mtc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_first_of_message,
    input  wire logic       s_last_of_message,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    localparam int AW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic             written_reg;
    logic             rd_ok_reg;
    logic             fwd_valid_reg;
    mtc_state_t       fwd_data_reg;

    logic [STATE_W-1:0] ram_rdata;
    mtc_state_t       cur;
    mtc_state_t       nxt;
    mtc_job_t         job;
    logic             emit;
    logic             job_ready;
    logic             s1_go;
    logic             s_accept;

    assign s_accept = s_valid && s_ready;
    assign s1_go    = s1_valid_reg && (!emit || job_ready);
    assign s_ready  = !s1_valid_reg || s1_go;

    mtc_ram #(
        .WIDTH(STATE_W),
        .DEPTH(STATE_DEPTH)
    ) u_state_ram (
        .aclk   (aclk),
        .wr_en  (s1_go),
        .wr_addr(AW'(0)),
        .wr_data(nxt),
        .rd_en  (s_accept),
        .rd_addr(AW'(0)),
        .rd_data(ram_rdata)
    );

    always_comb begin
        cur  = fwd_valid_reg ? fwd_data_reg : (rd_ok_reg ? mtc_state_t'(ram_rdata) : '0);
        nxt  = cur;
        emit = 1'b0;
        job  = '0;
        if (s1_first_reg) begin
            nxt = '0;
            nxt.decode_mode = is_symbol(s1_byte_reg);
        end
        if (!nxt.decode_mode) begin
            emit = 1'b1;
            job  = enc_lookup(s1_byte_reg);
        end else if (is_space(s1_byte_reg)) begin
            if (nxt.token_length != 4'd0) begin
                emit           = 1'b1;
                job.final_byte = dec_lookup(nxt);
            end
            nxt.token_symbols = '0;
            nxt.token_length  = '0;
            nxt.token_bad     = 1'b0;
        end else begin
            if (nxt.token_length < 4'd7) begin
                if (s1_byte_reg == CH_DASH) begin
                    nxt.token_symbols[nxt.token_length[2:0]] = 1'b1;
                end
                nxt.token_length = nxt.token_length + 4'd1;
            end else begin
                nxt.token_length = 4'd8;
            end
            if (!is_symbol(s1_byte_reg)) begin
                nxt.token_bad = 1'b1;
            end
            if (s1_last_reg) begin
                emit              = 1'b1;
                job.final_byte    = dec_lookup(nxt);
                nxt.token_symbols = '0;
                nxt.token_length  = '0;
                nxt.token_bad     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            written_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg  <= 1'b1;
                rd_ok_reg     <= written_reg;
                fwd_valid_reg <= s1_go;
            end else if (s1_go) begin
                s1_valid_reg  <= 1'b0;
            end
            if (s1_go) begin
                written_reg <= 1'b1;
            end
        end
        if (s_accept) begin
            s1_byte_reg  <= s_in_byte;
            s1_first_reg <= s_first_of_message;
            s1_last_reg  <= s_last_of_message;
            fwd_data_reg <= nxt;
        end
    end

    mtc_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (s1_valid_reg && emit),
        .job          (job),
        .job_ready    (job_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last_of_run(m_last_of_run)
    );

endmodule

`default_nettype wire

@@ tb/tb_morse_text_codec.sv @@
// Self-checking testbench for morse_text_codec: directed encode/decode cases, then random
// messages, with random gaps on the input side and random stalls on the result side.
// Depends on mtc_pkg (character constants) and the morse_text_codec RTL.
`timescale 1ns / 100ps

module tb_morse_text_codec;
    import mtc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
    } morse_word_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_first_of_message = 1'b0;
    logic       s_last_of_message = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    morse_word_t pending_words[$];
    int          fault_count = 0;
    bit          idle_on = 1'b0;
    int          rx_hold = 0;
    string       table_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890,!?.' ";

    // codec state as the block should hold it
    logic       dec_mode = 1'b0;
    logic [6:0] tok_dashes = '0;
    logic [3:0] tok_len = '0;
    logic       tok_bad = 1'b0;

    morse_text_codec dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_in_byte          (s_in_byte),
        .s_first_of_message (s_first_of_message),
        .s_last_of_message  (s_last_of_message),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_last_of_run      (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    function automatic string morse_of(input logic [7:0] c);
        case (c)
            "A": return ".-";      "B": return "-...";    "C": return "-.-.";
            "D": return "-..";     "E": return ".";       "F": return "..-.";
            "G": return "--.";     "H": return "....";    "I": return "..";
            "J": return ".---";    "K": return "-.-";     "L": return ".-..";
            "M": return "--";      "N": return "-.";      "O": return "---";
            "P": return ".--.";    "Q": return "--.-";    "R": return ".-.";
            "S": return "...";     "T": return "-";       "U": return "..-";
            "V": return "...-";    "W": return ".--";     "X": return "-..-";
            "Y": return "-.--";    "Z": return "--..";    "1": return ".----";
            "2": return "..---";   "3": return "...--";   "4": return "....-";
            "5": return ".....";   "6": return "-....";   "7": return "--...";
            "8": return "---..";   "9": return "----.";   "0": return "-----";
            ",": return "--..--";  "!": return "-.-.--";  "?": return "..--..";
            ".": return ".-.-.-";  "'": return ".----.";  " ": return ".......";
            default: return "";
        endcase
    endfunction

    function automatic logic [6:0] dash_mask(input string code);
        logic [6:0] m;
        m = '0;
        for (int i = 0; i < code.len() && i < 7; i++) begin
            if (code[i] == CH_DASH) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [7:0] token_letter();
        string code;
        if (tok_bad || tok_len == 4'd0 || tok_len > 4'd7) begin
            return CH_SPACE;
        end
        for (int i = 0; i < table_chars.len(); i++) begin
            code = morse_of(table_chars[i]);
            if (code.len() == int'(tok_len) && dash_mask(code) == tok_dashes) begin
                return table_chars[i];
            end
        end
        return CH_SPACE;
    endfunction

    function automatic void clear_token();
        tok_dashes = '0;
        tok_len    = '0;
        tok_bad    = 1'b0;
    endfunction

    // expected output words for one accepted input word
    function automatic void predict_word(input logic [7:0] b, input logic first,
                                         input logic last);
        logic [7:0] u;
        string      code;
        if (first) begin
            dec_mode = (b == CH_DOT || b == CH_DASH);
            clear_token();
        end
        if (!dec_mode) begin
            u = (b >= "a" && b <= "z") ? b - 8'h20 : b;
            code = morse_of(u);
            for (int i = 0; i < code.len() && i < 7; i++) begin
                pending_words.push_back('{ch: code[i], run_end: 1'b0});
            end
            pending_words.push_back('{ch: CH_SPACE, run_end: 1'b1});
        end else if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D)) begin
            if (tok_len != 4'd0) begin
                pending_words.push_back('{ch: token_letter(), run_end: 1'b1});
            end
            clear_token();
        end else begin
            if (tok_len < 4'd7) begin
                if (b == CH_DASH) begin
                    tok_dashes[tok_len[2:0]] = 1'b1;
                end
                tok_len = tok_len + 4'd1;
            end else begin
                tok_len = 4'd8;
            end
            if (b != CH_DOT && b != CH_DASH) begin
                tok_bad = 1'b1;
            end
            if (last) begin
                pending_words.push_back('{ch: token_letter(), run_end: 1'b1});
                clear_token();
            end
        end
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] blank_byte();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : 8'h09 + 8'(k);
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_in_byte          <= b;
        s_first_of_message <= first;
        s_last_of_message  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(b, first, last);
    endtask

    // result side: random stalls when idling is on
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            rx_hold = gap_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        morse_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                note_fault($sformatf("unexpected word %h last %b", m_out_byte, m_last_of_run));
            end else begin
                want = pending_words.pop_front();
                if (m_out_byte !== want.ch || m_last_of_run !== want.run_end) begin
                    note_fault($sformatf("expected %h last %b, got %h last %b",
                                         want.ch, want.run_end, m_out_byte, m_last_of_run));
                end
            end
        end
    end

    task automatic test_encode_directed();
        idle_on = 1'b1;
        send_word("A", 1'b0, 1'b0);        // no first word yet: encode after reset
        send_word("z", 1'b1, 1'b0);
        send_word("0", 1'b0, 1'b0);
        send_word(CH_SPACE, 1'b0, 1'b0);   // seven dots
        send_word(",", 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(CH_DOT, 1'b0, 1'b1);     // last has no effect here
    endtask

    task automatic test_decode_directed();
        idle_on = 1'b1;
        send_word(CH_DASH, 1'b1, 1'b0);
        send_word(CH_DOT, 1'b0, 1'b0);
        send_word(8'h0B, 1'b0, 1'b0);
        send_word(CH_SPACE, 1'b0, 1'b0);   // whitespace run, no token
        send_word(CH_DOT, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);      // malformed token flushed at end
        for (int i = 0; i < 8; i++) begin
            send_word(CH_DOT, i == 0, i == 7);  // overlong token
        end
        send_word(CH_DOT, 1'b1, 1'b0);
        send_word(CH_DASH, 1'b0, 1'b0);
        send_word(CH_DASH, 1'b1, 1'b1);    // new message drops pending token
        send_word(8'h0A, 1'b0, 1'b1);      // last word with nothing pending
    endtask

    task automatic test_random_messages(input int n_words, input bit with_idle);
        logic [7:0] msg[$];
        logic [7:0] b;
        string      code;
        int         sent, ntok, kind, start;
        bit         drop_last;
        idle_on = with_idle;
        sent = 0;
        while (sent < n_words) begin
            msg.delete();
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                msg.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 10) begin
                repeat ($urandom_range(1, 10)) begin
                    if ($urandom_range(0, 4) < 3) begin
                        b = table_chars[$urandom_range(0, 41)];
                        if (b >= "A" && b <= "Z" && $urandom_range(0, 1)) begin
                            b = b + 8'h20;
                        end
                    end else begin
                        b = 8'($urandom_range(0, 255));
                    end
                    msg.push_back(b);
                end
            end else begin
                ntok = $urandom_range(1, 4);
                for (int t = 0; t < ntok; t++) begin
                    kind = $urandom_range(0, 9);
                    if (kind == 7) begin
                        repeat ($urandom_range(1, 9)) begin
                            msg.push_back($urandom_range(0, 1) ? CH_DASH : CH_DOT);
                        end
                    end else begin
                        if (kind >= 8 && t == 0) begin
                            msg.push_back(CH_DOT);
                        end
                        start = msg.size();
                        code = morse_of(table_chars[$urandom_range(0, 41)]);
                        for (int i = 0; i < code.len(); i++) begin
                            msg.push_back(code[i]);
                        end
                        if (kind >= 8) begin
                            msg[start + $urandom_range(0, code.len() - 1)] =
                                8'($urandom_range(0, 255));
                        end
                    end
                    if (t < ntok - 1 || $urandom_range(0, 1)) begin
                        repeat ($urandom_range(1, 2)) msg.push_back(blank_byte());
                    end
                end
            end
            if (msg.size() == 1 && $urandom_range(0, 1)) begin
                send_word(msg[0], 1'b0, 1'($urandom_range(0, 1)));  // stray word
            end else begin
                drop_last = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < msg.size(); i++) begin
                    send_word(msg[i], i == 0, (i == msg.size() - 1) && !drop_last);
                end
            end
            sent += msg.size();
        end
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[morse_text_codec] ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_encode_directed();
        test_decode_directed();
        test_random_messages(50, 1'b0);
        test_random_messages(180, 1'b1);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("[morse_text_codec] OK");
        end else begin
            $display("[morse_text_codec] ERROR");
        end
        $finish;
    end

endmodule
